// ----- hw/rtl/fwt_pkg.sv -----
// Shared types, event codes and character constants for the Forth word tokenizer.
`default_nettype none
package fwt_pkg;
	localparam int WORD_MAX_DEFAULT   = 64;
	localparam int STRING_MAX_DEFAULT = 256;
	localparam int QUEUE_DEPTH        = 4;
	localparam int DATA_W             = 56;

	localparam logic [2:0] EV_WORD_CHAR   = 3'd0;
	localparam logic [2:0] EV_STRING_CHAR = 3'd1;
	localparam logic [2:0] EV_END         = 3'd2;
	localparam logic [2:0] EV_ERROR       = 3'd3;
	localparam logic [2:0] EV_DROP        = 3'd4;

	localparam logic [1:0] ERR_COMMENT    = 2'd0;
	localparam logic [1:0] ERR_STRING     = 2'd1;
	localparam logic [1:0] ERR_TOO_LONG   = 2'd2;

	localparam logic TK_WORD   = 1'b0;
	localparam logic TK_STRING = 1'b1;

	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_LPAREN    = 8'h28;
	localparam logic [7:0] CH_RPAREN    = 8'h29;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_VTAB      = 8'h0B;
	localparam logic [7:0] CH_FORMFEED  = 8'h0C;
	localparam logic [7:0] CH_RETURN    = 8'h0D;

	typedef struct packed {
		logic [2:0]  event_kind;
		logic [7:0]  token_char;
		logic        token_kind;
		logic [8:0]  token_length;
		logic [15:0] start_row;
		logic [15:0] start_column;
		logic [1:0]  error_code;
	} result_t;

	typedef struct packed {
		logic    second_valid;
		result_t first;
		result_t second;
	} group_t;
endpackage
`default_nettype wire

// ----- hw/rtl/fwt_front.sv -----
// Front end: accepts source bytes, tracks scan mode and position, builds result groups.
`default_nettype none
module fwt_front #(
	parameter int WORD_MAX   = fwt_pkg::WORD_MAX_DEFAULT,
	parameter int STRING_MAX = fwt_pkg::STRING_MAX_DEFAULT
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 s_tvalid,
	output logic                s_tready,
	input  wire  [7:0]          s_tdata,
	input  wire                 s_tlast,
	input  wire                 q_full,
	output logic                q_push,
	output fwt_pkg::group_t     q_group
);
	localparam logic [2:0] MODE_IDLE    = 3'd0;
	localparam logic [2:0] MODE_LINE    = 3'd1;
	localparam logic [2:0] MODE_PAREN   = 3'd2;
	localparam logic [2:0] MODE_WORD    = 3'd3;
	localparam logic [2:0] MODE_STRING  = 3'd4;
	localparam logic [2:0] MODE_HALTED  = 3'd5;

	logic [2:0]  mode_q, mode_d;
	logic [15:0] row_q, row_d, col_q, col_d;
	logic [15:0] trow_q, trow_d, tcol_q, tcol_d;
	logic [8:0]  cnt_q, cnt_d;
	fwt_pkg::result_t res [2];
	logic [1:0]  n;
	logic        accept;
	logic        space;
	logic [7:0]  c;

	function automatic fwt_pkg::result_t make_char(input logic [2:0] kind, input logic [7:0] ch);
		fwt_pkg::result_t r;
		r = '0;
		r.event_kind = kind;
		r.token_char = ch;
		return r;
	endfunction

	function automatic fwt_pkg::result_t make_end(input logic tk, input logic [8:0] len,
		input logic [15:0] row, input logic [15:0] col);
		fwt_pkg::result_t r;
		r = '0;
		r.event_kind   = fwt_pkg::EV_END;
		r.token_kind   = tk;
		r.token_length = len;
		r.start_row    = row;
		r.start_column = col;
		return r;
	endfunction

	function automatic fwt_pkg::result_t make_err(input logic [1:0] code,
		input logic [15:0] row, input logic [15:0] col);
		fwt_pkg::result_t r;
		r = '0;
		r.event_kind   = fwt_pkg::EV_ERROR;
		r.error_code   = code;
		r.start_row    = row;
		r.start_column = col;
		return r;
	endfunction

	assign c        = s_tdata;
	assign s_tready = !q_full;
	assign accept   = s_tvalid && !q_full;
	assign space    = (c == fwt_pkg::CH_SPACE) || (c == fwt_pkg::CH_TAB) ||
		(c == fwt_pkg::CH_NEWLINE) || (c == fwt_pkg::CH_VTAB) ||
		(c == fwt_pkg::CH_FORMFEED) || (c == fwt_pkg::CH_RETURN);

	always_comb begin
		mode_d = mode_q;
		row_d  = row_q;
		col_d  = col_q;
		trow_d = trow_q;
		tcol_d = tcol_q;
		cnt_d  = cnt_q;
		res[0] = '0;
		res[1] = '0;
		n      = 2'd0;
		unique case (mode_q)
			MODE_IDLE: begin
				priority if (space) begin
				end else if (c == fwt_pkg::CH_BACKSLASH) begin
					mode_d = MODE_LINE;
				end else if (c == fwt_pkg::CH_LPAREN) begin
					trow_d = row_q;
					tcol_d = col_q;
					cnt_d  = 9'd0;
					mode_d = MODE_PAREN;
				end else if (c == fwt_pkg::CH_QUOTE) begin
					trow_d = row_q;
					tcol_d = col_q;
					cnt_d  = 9'd0;
					mode_d = MODE_STRING;
				end else begin
					trow_d = row_q;
					tcol_d = col_q;
					mode_d = MODE_WORD;
					res[0] = make_char(fwt_pkg::EV_WORD_CHAR, c);
					n      = 2'd1;
					cnt_d  = 9'd1;
					if (cnt_d >= 9'(WORD_MAX)) begin
						res[1] = make_end(fwt_pkg::TK_WORD, cnt_d, trow_d, tcol_d);
						n      = 2'd2;
						mode_d = MODE_IDLE;
					end
				end
			end
			MODE_LINE: begin
				if (c == fwt_pkg::CH_NEWLINE) begin
					mode_d = MODE_IDLE;
				end
			end
			MODE_PAREN: begin
				if (c == fwt_pkg::CH_RPAREN) begin
					mode_d = MODE_IDLE;
				end
			end
			MODE_WORD: begin
				priority if (space) begin
					res[0] = make_end(fwt_pkg::TK_WORD, cnt_q, trow_q, tcol_q);
					n      = 2'd1;
					mode_d = MODE_IDLE;
				end else if (c == fwt_pkg::CH_QUOTE) begin
					res[0] = make_char(fwt_pkg::EV_DROP, 8'd0);
					n      = 2'd1;
					cnt_d  = 9'd0;
					mode_d = MODE_STRING;
				end else begin
					res[0] = make_char(fwt_pkg::EV_WORD_CHAR, c);
					n      = 2'd1;
					cnt_d  = cnt_q + 9'd1;
					if (cnt_d >= 9'(WORD_MAX)) begin
						res[1] = make_end(fwt_pkg::TK_WORD, cnt_d, trow_q, tcol_q);
						n      = 2'd2;
						mode_d = MODE_IDLE;
					end
				end
			end
			MODE_STRING: begin
				priority if (c == fwt_pkg::CH_QUOTE) begin
					res[0] = make_end(fwt_pkg::TK_STRING, cnt_q, trow_q, tcol_q);
					n      = 2'd1;
					mode_d = MODE_IDLE;
				end else if (c == fwt_pkg::CH_NEWLINE) begin
					res[0] = make_err(fwt_pkg::ERR_STRING, trow_q, tcol_q);
					n      = 2'd1;
					mode_d = MODE_HALTED;
				end else if (({1'b0, cnt_q} + 10'd1) >= 10'(STRING_MAX)) begin
					res[0] = make_err(fwt_pkg::ERR_TOO_LONG, trow_q, tcol_q);
					n      = 2'd1;
					mode_d = MODE_HALTED;
				end else begin
					res[0] = make_char(fwt_pkg::EV_STRING_CHAR, c);
					n      = 2'd1;
					cnt_d  = cnt_q + 9'd1;
				end
			end
			default: begin
				mode_d = MODE_HALTED;
			end
		endcase

		if (mode_d != MODE_HALTED) begin
			if (c == fwt_pkg::CH_NEWLINE) begin
				if (row_q != 16'hFFFF) begin
					row_d = row_q + 16'd1;
				end
				col_d = 16'd1;
			end else if (col_q != 16'hFFFF) begin
				col_d = col_q + 16'd1;
			end
		end

		if (s_tlast && mode_d != MODE_HALTED) begin
			if (mode_d == MODE_WORD) begin
				res[n[0]] = make_end(fwt_pkg::TK_WORD, cnt_d, trow_d, tcol_d);
				n         = n + 2'd1;
			end else if (mode_d == MODE_STRING) begin
				res[n[0]] = make_err(fwt_pkg::ERR_STRING, trow_d, tcol_d);
				n         = n + 2'd1;
				mode_d    = MODE_HALTED;
			end else if (mode_d == MODE_PAREN) begin
				res[n[0]] = make_err(fwt_pkg::ERR_COMMENT, trow_d, tcol_d);
				n         = n + 2'd1;
				mode_d    = MODE_HALTED;
			end
			if (mode_d != MODE_HALTED) begin
				mode_d = MODE_IDLE;
				row_d  = 16'd1;
				col_d  = 16'd1;
				trow_d = 16'd1;
				tcol_d = 16'd1;
				cnt_d  = 9'd0;
			end
		end
	end

	assign q_push               = accept && (n != 2'd0);
	assign q_group.second_valid = (n == 2'd2);
	assign q_group.first        = res[0];
	assign q_group.second       = res[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			row_q  <= 16'd1;
			col_q  <= 16'd1;
			trow_q <= 16'd1;
			tcol_q <= 16'd1;
			cnt_q  <= 9'd0;
		end else if (accept) begin
			mode_q <= mode_d;
			row_q  <= row_d;
			col_q  <= col_d;
			trow_q <= trow_d;
			tcol_q <= tcol_d;
			cnt_q  <= cnt_d;
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/fwt_queue.sv -----
// Short queue of result groups between the front end and the output stage.
`default_nettype none
module fwt_queue (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  wire fwt_pkg::group_t  push_group,
	output logic                  full,
	input  wire                   pop,
	output fwt_pkg::group_t       head,
	output logic                  empty
);
	localparam int DEPTH = fwt_pkg::QUEUE_DEPTH;
	localparam int AW    = $clog2(DEPTH);

	fwt_pkg::group_t entry_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [AW:0]     count_q;

	assign full  = (count_q == (AW+1)'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_group;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/fwt_back.sv -----
// Back end: splits result groups into single results and holds the output register.
`default_nettype none
module fwt_back (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire fwt_pkg::group_t   head,
	input  wire                    empty,
	output logic                   pop,
	output logic                   m_tvalid,
	input  wire                    m_tready,
	output fwt_pkg::result_t       out_result,
	output logic                   m_tlast
);
	logic             sel_q;
	logic             valid_q;
	logic             last_q;
	fwt_pkg::result_t res_q;
	logic             load;
	logic             group_end;

	assign load       = (!valid_q || m_tready) && !empty;
	assign group_end  = sel_q || !head.second_valid;
	assign pop        = load && group_end;
	assign m_tvalid   = valid_q;
	assign m_tlast    = last_q;
	assign out_result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else begin
			if (!valid_q || m_tready) begin
				valid_q <= !empty;
			end
			if (load) begin
				sel_q <= !group_end;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q  <= sel_q ? head.second : head.first;
			last_q <= group_end;
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/forth_word_tokenizer_unit.sv -----
// Top level of the Forth word tokenizer: front end, group queue and output stage.
//
//  Channel  Dir  tdata (low bit up)                                tuser       tlast
//  s_       in   source_byte[7:0]                                  -           last_byte
//  m_       out  token_char, token_kind, token_length, start_row,  event_kind  final_result
//                start_column, error_code, 4 zero bits
//
// One source byte is accepted per cycle while the queue has room.
// Each result leaves the single output register in its own cycle, so a byte with two
// results holds the output for both in turn; the four-entry queue absorbs such bursts.
// Results reach the output through a queue entry and then the output register.
// Reset returns to between tokens at row 1, column 1; after an error all bytes are
// accepted and dropped until reset.
`default_nettype none
module forth_word_tokenizer_unit #(
	parameter int WORD_MAX   = fwt_pkg::WORD_MAX_DEFAULT,
	parameter int STRING_MAX = fwt_pkg::STRING_MAX_DEFAULT
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        s_tvalid,
	output logic                       s_tready,
	input  wire  [7:0]                 s_tdata,   // source_byte
	input  wire                        s_tlast,
	output logic                       m_tvalid,
	input  wire                        m_tready,
	output logic [fwt_pkg::DATA_W-1:0] m_tdata,   // token_char, token_kind, token_length,
	                                              // start_row, start_column, error_code
	output logic [2:0]                 m_tuser,   // event_kind
	output logic                       m_tlast
);
	fwt_pkg::group_t  push_group, head;
	fwt_pkg::result_t out_result;
	logic             push, full, pop, empty;

	fwt_front #(
		.WORD_MAX   (WORD_MAX),
		.STRING_MAX (STRING_MAX)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (full),
		.q_push   (push),
		.q_group  (push_group)
	);

	fwt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_group (push_group),
		.full       (full),
		.pop        (pop),
		.head       (head),
		.empty      (empty)
	);

	fwt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.empty      (empty),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.out_result (out_result),
		.m_tlast    (m_tlast)
	);

	assign m_tuser = out_result.event_kind;
	assign m_tdata = {4'b0, out_result.error_code, out_result.start_column,
		out_result.start_row, out_result.token_length, out_result.token_kind,
		out_result.token_char};
endmodule
`default_nettype wire

// ----- hw/rtl/fwt_checker.sv -----
// Port checker for the Forth word tokenizer, bound to the top level.
`default_nettype none
module fwt_checker (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        m_tvalid,
	input wire                        m_tready,
	input wire [fwt_pkg::DATA_W-1:0]  m_tdata,
	input wire [2:0]                  m_tuser,
	input wire                        m_tlast
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output changed while stalled");

	a_char_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == fwt_pkg::EV_WORD_CHAR || m_tuser == fwt_pkg::EV_STRING_CHAR)
		|-> m_tdata[fwt_pkg::DATA_W-1:8] == '0)
		else $error("character result carries token fields");

	a_end_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == fwt_pkg::EV_END |-> m_tdata[33:18] != 16'd0 &&
		m_tdata[49:34] != 16'd0)
		else $error("token end without start position");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == fwt_pkg::EV_ERROR |-> m_tlast)
		else $error("error is not the final result of its byte");

	a_err_halt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tuser == fwt_pkg::EV_ERROR |=> !m_tvalid)
		else $error("result after error");
endmodule

bind forth_word_tokenizer_unit fwt_checker u_fwt_checker (.*);
`default_nettype wire
